// ===== sv/kfrp_pkg.sv =====
// ----------------------------------------------------------------------------
// kfrp_pkg
// Shared types, register indexes and Shift-JIS helpers for the kanji font
// register port.
// ----------------------------------------------------------------------------
package kfrp_pkg;

  // Default store sizes
  localparam int KFRP_WIDE_GLYPHS = 11280;
  localparam int KFRP_NARROW_ROWS = 19;

  // Width of a glyph sequence number (largest reachable value is 11279)
  localparam int SEQ_W = 14;

  // Bus access codes
  typedef enum logic [1:0] {
    OP_INDEX_WR = 2'd0,
    OP_DATA_WR  = 2'd1,
    OP_DATA_RD  = 2'd2
  } kfrp_op_t;

  // Register indexes
  localparam logic [5:0] IDX_CUR_HI   = 6'h0E;
  localparam logic [5:0] IDX_CUR_LO   = 6'h0F;
  localparam logic [5:0] IDX_EXT_BASE = 6'h20;
  localparam logic [5:0] IDX_DUP_BASE = 6'h28;
  localparam logic [5:0] IDX_MODE1    = 6'h21;
  localparam logic [5:0] IDX_GROUP    = 6'h23;
  localparam logic [5:0] IDX_FIRST    = 6'h24;
  localparam logic [5:0] IDX_SECOND   = 6'h25;
  localparam logic [5:0] IDX_PATTERN  = 6'h26;
  localparam logic [5:0] IDX_STATUS   = 6'h27;
  localparam logic [5:0] IDX_PAD_UP   = 6'h29;
  localparam logic [5:0] IDX_PAD_LO   = 6'h2A;
  localparam logic [5:0] IDX_PAD_NORM = 6'h2B;
  localparam logic [5:0] IDX_CUR_MODE = 6'h2D;
  localparam logic [5:0] IDX_INVALID  = 6'h30;

  // Index port decode windows
  localparam logic [7:0] PORT_EXT_LO = 8'hB8;
  localparam logic [7:0] PORT_EXT_HI = 8'hBF;
  localparam logic [7:0] PORT_DUP_LO = 8'hD8;
  localparam logic [7:0] PORT_DUP_HI = 8'hDF;
  localparam logic [7:0] PORT_CRTC_HI = 8'h1F;

  // Fixed values
  localparam logic [7:0] MODE1_RESET  = 8'h48;
  localparam logic [7:0] STATUS_VALUE = 8'h03;
  localparam logic [7:0] READ_NONE    = 8'hFF;
  localparam logic [5:0] ROW_LIMIT    = 6'd32;
  localparam logic [7:0] FONT_LEAD_LO = 8'hF0;
  localparam logic [7:0] FONT_LEAD_HI = 8'hF3;
  localparam logic [7:0] PAD_NORM_KNEE = 8'd17;
  localparam logic [7:0] PAD_UP_KNEE   = 8'd33;
  localparam int         SJIS_ROW_CODES = 188;

  // Source of the byte shown on a data read
  typedef enum logic [1:0] {
    RD_CONST  = 2'd0,
    RD_WIDE   = 2'd1,
    RD_NARROW = 2'd2
  } kfrp_rd_sel_t;

  // Glyph store access strobes
  typedef struct packed {
    logic wide_we;
    logic wide_re;
    logic narrow_we;
    logic narrow_re;
  } kfrp_mem_ctl_t;

  function automatic logic sjis_lead(input logic [7:0] c);
    return (c >= 8'h81 && c <= 8'h9F) || (c >= 8'hE0 && c <= 8'hFC);
  endfunction

  function automatic logic sjis_trail(input logic [7:0] c);
    return (c >= 8'h40 && c <= 8'h7E) || (c >= 8'h80 && c <= 8'hFC);
  endfunction

  // Glyph sequence number of a lead/trail pair (meaningful for valid codes)
  function automatic logic [SEQ_W-1:0] sjis_seq(input logic [7:0] first,
                                                input logic [7:0] second);
    logic [7:0] a;
    logic [7:0] b;
    a = first - 8'h81;
    if (a > 8'h5E) begin
      a = a - 8'h40;
    end
    b = second - 8'h40;
    if (b > 8'h3F) begin
      b = b - 8'd1;
    end
    return SEQ_W'(a[5:0]) * SEQ_W'(SJIS_ROW_CODES) + SEQ_W'(b);
  endfunction

endpackage

// ===== sv/kfrp_if.sv =====
// ----------------------------------------------------------------------------
// kfrp_in_if / kfrp_out_if
// Valid/ready channels carrying bus requests in and port results out.
// ----------------------------------------------------------------------------
interface kfrp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] bus_data;

  modport source (output valid, operation, bus_data, input ready);
  modport sink   (input valid, operation, bus_data, output ready);
endinterface

interface kfrp_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        read_data;
  logic [17:0]       cursor_address;
  logic              cursor_enabled;
  logic              cursor_blink_off;
  logic              text_render_on;
  logic              bank_by_attribute;
  logic              bank_invert;
  logic signed [8:0] pad_normal;
  logic signed [8:0] pad_upper;
  logic signed [8:0] pad_lower;

  modport source (output valid, read_data, cursor_address, cursor_enabled,
                  cursor_blink_off, text_render_on, bank_by_attribute,
                  bank_invert, pad_normal, pad_upper, pad_lower,
                  input ready);
  modport sink   (input valid, read_data, cursor_address, cursor_enabled,
                  cursor_blink_off, text_render_on, bank_by_attribute,
                  bank_invert, pad_normal, pad_upper, pad_lower,
                  output ready);
endinterface

// ===== sv/kfrp_glyph_store.sv =====
// ----------------------------------------------------------------------------
// kfrp_glyph_store
// Wide and narrow glyph memories with registered reads and a clearing sweep
// after reset.
// ----------------------------------------------------------------------------
module kfrp_glyph_store #(
  parameter int   WIDE_GLYPHS = kfrp_pkg::KFRP_WIDE_GLYPHS,
  parameter int   NARROW_ROWS = kfrp_pkg::KFRP_NARROW_ROWS,
  localparam int  WA_W = $clog2(WIDE_GLYPHS * 32),
  localparam int  NA_W = $clog2(256 * NARROW_ROWS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kfrp_pkg::kfrp_mem_ctl_t ctl,
  input  logic [WA_W-1:0]         wide_addr,
  input  logic [NA_W-1:0]         narrow_addr,
  input  logic [7:0]              wr_data,
  output logic [7:0]              wide_q,
  output logic [7:0]              narrow_q,
  output logic                    busy
);
  import kfrp_pkg::*;

  localparam int WIDE_DEPTH   = WIDE_GLYPHS * 32;
  localparam int NARROW_DEPTH = 256 * NARROW_ROWS;
  localparam int CLR_DEPTH    = (WIDE_DEPTH > NARROW_DEPTH) ? WIDE_DEPTH : NARROW_DEPTH;
  localparam int CLR_W        = $clog2(CLR_DEPTH);
  localparam logic [CLR_W-1:0] CLR_LAST   = CLR_W'(CLR_DEPTH - 1);
  localparam logic [CLR_W:0]   WIDE_LIM   = (CLR_W+1)'(WIDE_DEPTH);
  localparam logic [CLR_W:0]   NARROW_LIM = (CLR_W+1)'(NARROW_DEPTH);

  logic [7:0] wide_mem   [WIDE_DEPTH];
  logic [7:0] narrow_mem [NARROW_DEPTH];

  logic [CLR_W-1:0] clr_cnt_r;
  logic             clr_busy_r;
  logic             clr_wide;
  logic             clr_narrow;
  logic [WA_W-1:0]  wa;
  logic [NA_W-1:0]  na;

  // Sweep every entry once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == CLR_LAST) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // Select the sweep address while clearing
  always_comb begin
    clr_wide   = clr_busy_r && ({1'b0, clr_cnt_r} < WIDE_LIM);
    clr_narrow = clr_busy_r && ({1'b0, clr_cnt_r} < NARROW_LIM);
    wa         = clr_busy_r ? clr_cnt_r[WA_W-1:0] : wide_addr;
    na         = clr_busy_r ? clr_cnt_r[NA_W-1:0] : narrow_addr;
  end

  // Wide store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (clr_wide || ctl.wide_we) begin
      wide_mem[wa] <= clr_wide ? 8'h00 : wr_data;
    end
    if (ctl.wide_re) begin
      wide_q <= wide_mem[wa];
    end
  end

  // Narrow store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (clr_narrow || ctl.narrow_we) begin
      narrow_mem[na] <= clr_narrow ? 8'h00 : wr_data;
    end
    if (ctl.narrow_re) begin
      narrow_q <= narrow_mem[na];
    end
  end

  assign busy = clr_busy_r;

endmodule

// ===== sv/kanji_font_register_port_unit.sv =====
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while out_chan.ready is high; each pattern access uses one port of
// one glyph store, and the result register frees as the result is taken.
// Reset: synchronous, active low; afterwards every entry of both glyph stores
// is swept to zero, with in_chan.ready low throughout.
// ----------------------------------------------------------------------------
// kanji_font_register_port_unit
// Index/data register port with cursor, bank and padding decode and
// Shift-JIS addressed glyph store access.
// ----------------------------------------------------------------------------
module kanji_font_register_port_unit #(
  parameter int  WIDE_GLYPHS = kfrp_pkg::KFRP_WIDE_GLYPHS,
  parameter int  NARROW_ROWS = kfrp_pkg::KFRP_NARROW_ROWS
) (
  input logic         clk,
  input logic         rst_n,
  kfrp_in_if.sink     in_chan,
  kfrp_out_if.source  out_chan
);
  import kfrp_pkg::*;

  localparam int WA_W = $clog2(WIDE_GLYPHS * 32);
  localparam int NA_W = $clog2(256 * NARROW_ROWS);
  localparam logic [SEQ_W:0] GLYPH_LIM = (SEQ_W+1)'(WIDE_GLYPHS);
  localparam logic [5:0]     NROW_LIM  = 6'(NARROW_ROWS);

  // State
  logic [5:0]        idx_r,       idx_nxt;
  logic [7:0]        ext_r [16];
  logic [7:0]        ext_nxt [16];
  logic [7:0]        cur_hi_r,    cur_hi_nxt;
  logic [7:0]        cur_lo_r,    cur_lo_nxt;
  logic [5:0]        row_r,       row_nxt;
  logic              cur_en_r,    cur_en_nxt;
  logic              blink_off_r, blink_off_nxt;
  logic signed [8:0] pad_norm_r,  pad_norm_nxt;
  logic signed [8:0] pad_up_r,    pad_up_nxt;
  logic signed [8:0] pad_lo_r,    pad_lo_nxt;
  logic              out_valid_r, out_valid_nxt;
  kfrp_rd_sel_t      rd_sel_r,    rd_sel_nxt;
  logic [7:0]        rd_const_r,  rd_const_nxt;

  // Request decode
  logic             accept;
  logic             busy;
  logic [7:0]       v;
  logic             data_wr;
  logic             data_rd;
  logic             is_ext;
  logic             is_pattern;
  logic [7:0]       first;
  logic [7:0]       second;
  logic [SEQ_W-1:0] seq;
  logic             first_lead;
  logic             first_font;
  logic             wide_ok;
  logic             narrow_ok;
  logic [WA_W-1:0]  wide_addr;
  logic [NA_W-1:0]  narrow_addr;
  kfrp_mem_ctl_t    mem_ctl;
  logic [7:0]       wide_q;
  logic [7:0]       narrow_q;
  logic [7:0]       group;

  kfrp_glyph_store #(
    .WIDE_GLYPHS (WIDE_GLYPHS),
    .NARROW_ROWS (NARROW_ROWS)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (mem_ctl),
    .wide_addr   (wide_addr),
    .narrow_addr (narrow_addr),
    .wr_data     (v),
    .wide_q      (wide_q),
    .narrow_q    (narrow_q),
    .busy        (busy)
  );

  // Accept while the glyph store is not sweeping and the result slot is free or being emptied
  assign in_chan.ready = !busy && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;
  assign v             = in_chan.bus_data;

  // Decode the access and form glyph addresses
  always_comb begin
    data_wr     = accept && (in_chan.operation == OP_DATA_WR);
    data_rd     = accept && (in_chan.operation == OP_DATA_RD);
    is_ext      = (idx_r[5:4] == IDX_EXT_BASE[5:4]);
    is_pattern  = (idx_r == IDX_PATTERN);
    first       = ext_r[IDX_FIRST[3:0]];
    second      = ext_r[IDX_SECOND[3:0]];
    seq         = sjis_seq(first, second);
    first_lead  = sjis_lead(first);
    first_font  = (first >= FONT_LEAD_LO) && (first <= FONT_LEAD_HI);
    wide_ok     = first_lead && sjis_trail(second) && (row_r < ROW_LIMIT) &&
                  ({1'b0, seq} < GLYPH_LIM);
    narrow_ok   = (row_r < NROW_LIM);
    wide_addr   = WA_W'({seq, row_r[4:0]});
    narrow_addr = NA_W'(first) * NA_W'(NARROW_ROWS) + NA_W'(row_r);

    mem_ctl.wide_we   = data_wr && is_pattern && first_font && wide_ok;
    mem_ctl.narrow_we = data_wr && is_pattern && !first_font && narrow_ok;
    mem_ctl.wide_re   = data_rd && is_pattern && first_lead && wide_ok;
    mem_ctl.narrow_re = data_rd && is_pattern && !first_lead && narrow_ok;
  end

  // Next state of the register file and derived values
  always_comb begin
    idx_nxt       = idx_r;
    ext_nxt       = ext_r;
    cur_hi_nxt    = cur_hi_r;
    cur_lo_nxt    = cur_lo_r;
    row_nxt       = row_r;
    cur_en_nxt    = cur_en_r;
    blink_off_nxt = blink_off_r;
    pad_norm_nxt  = pad_norm_r;
    pad_up_nxt    = pad_up_r;
    pad_lo_nxt    = pad_lo_r;

    // Index write: map the port byte onto a register index
    if (accept && (in_chan.operation == OP_INDEX_WR)) begin
      if (v >= PORT_EXT_LO && v <= PORT_EXT_HI) begin
        idx_nxt = IDX_EXT_BASE | {3'b000, v[2:0]};
      end else if (v >= PORT_DUP_LO && v <= PORT_DUP_HI) begin
        idx_nxt = IDX_DUP_BASE | {3'b000, v[2:0]};
      end else if (v <= PORT_CRTC_HI) begin
        idx_nxt = v[5:0];
      end else begin
        idx_nxt = IDX_INVALID;
      end
    end

    // Data write: update the register and its side effects
    if (data_wr) begin
      if (is_ext) begin
        ext_nxt[idx_r[3:0]] = v;
      end
      case (idx_r)
        IDX_CUR_HI:   cur_hi_nxt = v;
        IDX_CUR_LO:   cur_lo_nxt = v;
        IDX_CUR_MODE: begin
          cur_en_nxt    = v[7];
          blink_off_nxt = ~v[5];
        end
        IDX_FIRST, IDX_SECOND: row_nxt = '0;
        IDX_PAD_NORM: pad_norm_nxt = (v <= PAD_NORM_KNEE) ? $signed({1'b0, v} + 9'd1)
                                                          : $signed({1'b0, v} - 9'd31);
        IDX_PAD_UP:   pad_up_nxt = (v <= PAD_UP_KNEE) ? $signed({1'b0, v} + 9'd4)
                                                      : $signed({1'b0, v} - 9'd60);
        IDX_PAD_LO:   pad_lo_nxt = $signed({1'b0, v} - 9'd15);
        default: ;
      endcase
    end

    // Advance the font row on every pattern access, saturating
    if ((data_wr || data_rd) && is_pattern && (row_r < ROW_LIMIT)) begin
      row_nxt = row_r + 6'd1;
    end
  end

  // Result slot: select the read byte source
  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    rd_sel_nxt    = rd_sel_r;
    rd_const_nxt  = rd_const_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      rd_sel_nxt    = RD_CONST;
      rd_const_nxt  = READ_NONE;
      if (data_rd && is_ext) begin
        if (is_pattern) begin
          if (mem_ctl.wide_re) begin
            rd_sel_nxt = RD_WIDE;
          end else if (mem_ctl.narrow_re) begin
            rd_sel_nxt = RD_NARROW;
          end
        end else if (idx_r == IDX_STATUS) begin
          rd_const_nxt = STATUS_VALUE;
        end else begin
          rd_const_nxt = ext_r[idx_r[3:0]];
        end
      end
    end
  end

  // Hold control and register state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cur_hi_r    <= '0;
      cur_lo_r    <= '0;
      row_r       <= '0;
      cur_en_r    <= 1'b0;
      blink_off_r <= 1'b0;
      pad_norm_r  <= '0;
      pad_up_r    <= '0;
      pad_lo_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        ext_r[i] <= (i == int'(IDX_MODE1[3:0])) ? MODE1_RESET : 8'h00;
      end
    end else begin
      idx_r       <= idx_nxt;
      cur_hi_r    <= cur_hi_nxt;
      cur_lo_r    <= cur_lo_nxt;
      row_r       <= row_nxt;
      cur_en_r    <= cur_en_nxt;
      blink_off_r <= blink_off_nxt;
      pad_norm_r  <= pad_norm_nxt;
      pad_up_r    <= pad_up_nxt;
      pad_lo_r    <= pad_lo_nxt;
      out_valid_r <= out_valid_nxt;
      ext_r       <= ext_nxt;
    end
  end

  // Hold the read payload
  always_ff @(posedge clk) begin
    rd_sel_r   <= rd_sel_nxt;
    rd_const_r <= rd_const_nxt;
  end

  // Drive the result channel
  assign group = ext_r[IDX_GROUP[3:0]];

  always_comb begin
    case (rd_sel_r)
      RD_WIDE:   out_chan.read_data = wide_q;
      RD_NARROW: out_chan.read_data = narrow_q;
      default:   out_chan.read_data = rd_const_r;
    endcase
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.cursor_address    = {cur_hi_r, cur_lo_r, 2'b00};
  assign out_chan.cursor_enabled    = cur_en_r;
  assign out_chan.cursor_blink_off  = blink_off_r;
  assign out_chan.text_render_on    = ~ext_r[IDX_MODE1[3:0]][6];
  assign out_chan.bank_by_attribute = group[0] ^ group[1];
  assign out_chan.bank_invert       = group[1];
  assign out_chan.pad_normal        = pad_norm_r;
  assign out_chan.pad_upper         = pad_up_r;
  assign out_chan.pad_lower         = pad_lo_r;

  // Checks
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_chan.ready)
    else $error("request taken during glyph store sweep");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  a_row_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_LIMIT)
    else $error("font row beyond saturation limit");

  a_row_advances: assert property (@(posedge clk) disable iff (!rst_n)
    ((data_wr || data_rd) && is_pattern && (row_r < ROW_LIMIT))
      |=> (row_r == $past(row_r) + 6'd1))
    else $error("font row failed to advance on pattern access");

  a_one_store_access: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(mem_ctl))
    else $error("more than one glyph store access for one request");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_INVALID)
    else $error("register index out of range");

endmodule
